FILE: rtl/assert_macros.svh
// assertion macros shared by the rtl files
// expects signals named clk and rst in the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

FILE: rtl/lseg_pkg.sv
// types, constants and helper functions of the led strip effect generator
// no dependencies
`default_nettype none
package lseg_pkg;

  localparam int LED_COUNT_DEFAULT = 10;
  localparam int LED_IDX_W         = 6;
  localparam int JOB_QUEUE_DEPTH   = 2;

  localparam int SCALE_NUM     = 100;
  localparam int BLUE_RESET    = 100;
  localparam int BREATHE_STEP  = 10;
  localparam int BREATHE_TOP   = 250;
  localparam int RAINBOW_STEP  = 3;
  localparam int FULL_GAIN     = 255;

  typedef enum logic [2:0] {
    MODE_OFF     = 3'd0,
    MODE_STATIC  = 3'd1,
    MODE_FILL    = 3'd2,
    MODE_BLINK   = 3'd3,
    MODE_BREATHE = 3'd4,
    MODE_RAINBOW = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    CFG_EFFECT_MODE = 2'd0,
    CFG_BASE_RED    = 2'd1,
    CFG_BASE_GREEN  = 2'd2,
    CFG_BASE_BLUE   = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    JOB_SOLID   = 2'd0,
    JOB_FILL    = 2'd1,
    JOB_RAINBOW = 2'd2
  } job_kind_t;

  typedef enum logic [1:0] {
    F_IDLE = 2'd0,
    F_MUL  = 2'd1,
    F_PUSH = 2'd2
  } front_state_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    job_kind_t  kind;
    rgb_t       color;
    logic [6:0] fill_pos;
    logic [7:0] offset;
  } job_t;

  // floor(v / 255) for v below 65280
  function automatic logic [7:0] div255(input logic [15:0] v);
    logic [16:0] s;
    s = {1'b0, v} + 17'(v[15:8]) + 17'd1;
    return s[15:8];
  endfunction

  function automatic logic [31:0] mode_interval(input mode_t m);
    logic [31:0] t;
    case (m)
      MODE_OFF:     t = 32'd500;
      MODE_STATIC:  t = 32'd100;
      MODE_FILL:    t = 32'd100;
      MODE_BLINK:   t = 32'd500;
      MODE_BREATHE: t = 32'd50;
      default:      t = 32'd40;
    endcase
    return t;
  endfunction

  // three-segment color wheel
  function automatic rgb_t wheel(input logic [7:0] p);
    logic [7:0] q;
    logic [7:0] k;
    rgb_t c;
    q = 8'd255 - p;
    if (q < 8'd85) begin
      k = 8'(q * 3);
      c.red = 8'd255 - k; c.green = 8'd0; c.blue = k;
    end else if (q < 8'd170) begin
      k = 8'((q - 8'd85) * 3);
      c.red = 8'd0; c.green = k; c.blue = 8'd255 - k;
    end else begin
      k = 8'((q - 8'd170) * 3);
      c.red = k; c.green = 8'd255 - k; c.blue = 8'd0;
    end
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/lseg_ifs.sv
// stream and write-port interfaces of the led strip effect generator
// depends on lseg_pkg for the job item type
`default_nettype none
interface lseg_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

interface lseg_now_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_ms;
  modport source(output valid, now_ms, input ready);
  modport sink(input valid, now_ms, output ready);
endinterface

interface lseg_led_if;
  logic       valid;
  logic       ready;
  logic [5:0] led_index;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       frame_end;
  modport source(output valid, led_index, red, green, blue, frame_end, input ready);
  modport sink(input valid, led_index, red, green, blue, frame_end, output ready);
endinterface

interface lseg_job_if;
  logic             valid;
  logic             ready;
  lseg_pkg::job_t   job;
  modport source(output valid, job, input ready);
  modport sink(input valid, job, output ready);
endinterface
`default_nettype wire

FILE: rtl/lseg_front.sv
// front end: timestamp check, animation state update, frame color products
// depends on lseg_pkg and lseg_ifs
`default_nettype none
module lseg_front #(
  parameter int LED_COUNT = lseg_pkg::LED_COUNT_DEFAULT
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire lseg_pkg::mode_t mode,
  input  wire lseg_pkg::rgb_t  base,
  lseg_now_if.sink           tick,
  lseg_job_if.source         job_out
);
  import lseg_pkg::*;

  front_state_t state, state_next;

  logic [31:0] last_ms;
  logic [6:0]  fill_pos;
  logic        blink_on;
  logic        breathe_falling;
  logic [7:0]  breathe_level;
  logic [8:0]  rainbow_off;

  job_kind_t   kind;
  logic [6:0]  fill_hold;
  logic [7:0]  off_hold;
  logic [7:0]  gain;
  logic [15:0] prod_r, prod_g, prod_b;

  logic        accept;
  logic        update;
  logic [31:0] elapsed;
  logic [8:0]  level_sum;
  logic [7:0]  level_next;
  logic        falling_next;
  logic [8:0]  off_sum;

  assign tick.ready = (state == F_IDLE);
  assign accept     = tick.valid && tick.ready;
  assign elapsed    = tick.now_ms - last_ms;
  assign update     = !elapsed[31] && (elapsed > mode_interval(mode));
  assign off_sum    = rainbow_off + 9'(RAINBOW_STEP);

  always_comb begin
    level_sum = {1'b0, breathe_level} + 9'(BREATHE_STEP);
    if (!breathe_falling) begin
      level_next   = level_sum[8] ? 8'd255 : level_sum[7:0];
      falling_next = (level_next >= 8'(BREATHE_TOP));
    end else begin
      level_next   = (breathe_level < 8'(BREATHE_STEP)) ? 8'd0
                                                        : breathe_level - 8'(BREATHE_STEP);
      falling_next = (level_next != 8'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: if (accept && update) state_next = F_MUL;
      F_MUL:  state_next = F_PUSH;
      F_PUSH: if (job_out.ready) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  // animation state
  always_ff @(posedge clk) begin
    if (rst) begin
      last_ms         <= '0;
      fill_pos        <= '0;
      blink_on        <= 1'b0;
      breathe_falling <= 1'b0;
      breathe_level   <= '0;
      rainbow_off     <= '0;
    end else if (accept && update) begin
      last_ms <= tick.now_ms;
      case (mode)
        MODE_FILL: begin
          fill_pos <= (fill_pos >= 7'(LED_COUNT)) ? 7'd0 : fill_pos + 7'd1;
        end
        MODE_BLINK: blink_on <= !blink_on;
        MODE_BREATHE: begin
          breathe_level   <= level_next;
          breathe_falling <= falling_next;
        end
        MODE_RAINBOW: rainbow_off <= off_sum[8] ? 9'd0 : off_sum;
        default: ;
      endcase
    end
  end

  // job fields captured on an update, color products formed in F_MUL
  always_ff @(posedge clk) begin
    if (accept && update) begin
      fill_hold <= fill_pos;
      off_hold  <= off_sum[7:0];
      case (mode)
        MODE_OFF:     begin kind <= JOB_SOLID;   gain <= 8'd0; end
        MODE_STATIC:  begin kind <= JOB_SOLID;   gain <= 8'(FULL_GAIN); end
        MODE_FILL:    begin kind <= JOB_FILL;    gain <= 8'(FULL_GAIN); end
        MODE_BLINK:   begin
          kind <= JOB_SOLID;
          gain <= blink_on ? 8'd0 : 8'(FULL_GAIN);
        end
        MODE_BREATHE: begin kind <= JOB_SOLID;   gain <= level_next; end
        default:      begin kind <= JOB_RAINBOW; gain <= 8'd0; end
      endcase
    end
    if (state == F_MUL) begin
      prod_r <= base.red   * gain;
      prod_g <= base.green * gain;
      prod_b <= base.blue  * gain;
    end
  end

  assign job_out.valid          = (state == F_PUSH);
  assign job_out.job.kind       = kind;
  assign job_out.job.color.red   = div255(prod_r);
  assign job_out.job.color.green = div255(prod_g);
  assign job_out.job.color.blue  = div255(prod_b);
  assign job_out.job.fill_pos   = fill_hold;
  assign job_out.job.offset     = off_hold;

endmodule
`default_nettype wire

FILE: rtl/lseg_queue.sv
// short job queue between front end and pixel writer
// depends on lseg_pkg and lseg_ifs
`default_nettype none
module lseg_queue (
  input  wire logic  clk,
  input  wire logic  rst,
  lseg_job_if.sink   wr,
  lseg_job_if.source rd
);
  import lseg_pkg::*;

  localparam int DEPTH = JOB_QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign wr.ready = (count != CNT_W'(DEPTH));
  assign rd.valid = (count != '0);
  assign rd.job   = mem[rd_ptr];
  assign push     = wr.valid && wr.ready;
  assign pop      = rd.valid && rd.ready;

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr.job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      if (push && !pop)      count <= count + CNT_W'(1);
      else if (pop && !push) count <= count - CNT_W'(1);
    end
  end

endmodule
`default_nettype wire

FILE: rtl/lseg_back.sv
// pixel writer: expands one job into one color write per led
// depends on lseg_pkg, lseg_ifs and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module lseg_back #(
  parameter int LED_COUNT = lseg_pkg::LED_COUNT_DEFAULT
) (
  input  wire logic  clk,
  input  wire logic  rst,
  lseg_job_if.sink   job_in,
  lseg_led_if.source pixel
);
  import lseg_pkg::*;

  // rainbow hue base (i*256/LED_COUNT) walked down as quotient and remainder
  localparam int STEP_Q  = 256 / LED_COUNT;
  localparam int STEP_R  = 256 % LED_COUNT;
  localparam int START_Q = (LED_COUNT - 1) * 256 / LED_COUNT;
  localparam int START_R = (LED_COUNT - 1) * 256 % LED_COUNT;
  localparam logic [LED_IDX_W-1:0] LAST = LED_IDX_W'(LED_COUNT - 1);

  logic                 busy;
  logic [LED_IDX_W-1:0] led_cnt;
  job_t                 job;
  logic [7:0]           quo;
  logic [5:0]           rem;

  logic                 pix_valid;
  logic [LED_IDX_W-1:0] pix_idx;
  rgb_t                 pix_color;
  logic                 pix_end;

  logic                 adv;
  logic                 borrow;
  rgb_t                 color;

  assign adv          = !pix_valid || pixel.ready;
  assign job_in.ready = !busy;
  assign borrow       = (rem < 6'(STEP_R));

  always_comb begin
    case (job.kind)
      JOB_SOLID: color = job.color;
      JOB_FILL:  color = ({1'b0, led_cnt} < job.fill_pos) ? job.color : '0;
      JOB_RAINBOW: color = wheel(quo + job.offset);
      default:   color = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      pix_valid <= 1'b0;
    end else begin
      if (!busy && job_in.valid) begin
        busy <= 1'b1;
      end else if (busy && adv && led_cnt == LAST) begin
        busy <= 1'b0;
      end
      if (adv) pix_valid <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (!busy && job_in.valid) begin
      job     <= job_in.job;
      led_cnt <= '0;
      quo     <= 8'(START_Q);
      rem     <= 6'(START_R);
    end else if (busy && adv) begin
      led_cnt <= led_cnt + LED_IDX_W'(1);
      if (borrow) begin
        quo <= quo - 8'(STEP_Q) - 8'd1;
        rem <= 6'({1'b0, rem} + 7'(LED_COUNT - STEP_R));
      end else begin
        quo <= quo - 8'(STEP_Q);
        rem <= rem - 6'(STEP_R);
      end
    end
    if (busy && adv) begin
      pix_idx   <= led_cnt;
      pix_color <= color;
      pix_end   <= (led_cnt == LAST);
    end
  end

  assign pixel.valid     = pix_valid;
  assign pixel.led_index = pix_idx;
  assign pixel.red       = pix_color.red;
  assign pixel.green     = pix_color.green;
  assign pixel.blue      = pix_color.blue;
  assign pixel.frame_end = pix_end;

  `ASSERT_CLK(a_cnt_range, busy |-> led_cnt <= LAST, "led counter past the strip")
  `ASSERT_CLK(a_rem_range, busy |-> {1'b0, rem} < 7'(LED_COUNT), "hue remainder out of range")
  `ASSERT_CLK(a_next_led, pix_valid && pixel.ready && !pix_end |=> pix_valid && pix_idx == LED_IDX_W'($past(pix_idx) + 1), "frame write skipped")

endmodule
`default_nettype wire

FILE: rtl/led_strip_effect_generator.sv
// led strip effect generator, top level: config registers, front end, queue, writer
// depends on lseg_pkg, lseg_ifs, lseg_front, lseg_queue, lseg_back
//
// usage:
//   cfg   : write port, index 0 effect mode, 1..3 base red/green/blue, always ready.
//           write only while the block is idle.
//   tick  : one item per millisecond timestamp. an item that does not start a frame
//           is taken without dropping tick.ready; one that does holds it low in F_MUL
//           and F_PUSH (longer while the queue is full) while frame colors are formed.
//   pixel : LED_COUNT writes per frame in led order, frame_end on the last one.
// path: a frame's item passes F_MUL, F_PUSH, the job queue, the writer's job register
//   and its output register before the first write is valid.
// throughput: one led per cycle while pixel.ready is high, plus a load step per frame;
//   the two-entry job queue lets the front end take further items during a frame.
// stall: when pixel.ready is low the writer holds its output register; once the
//   queue is full the front end holds its job and stops taking items.
// reset: rst (synchronous) clears the queue, the writer and the animation state;
//   mode off, base color 0/0/100.
`default_nettype none
module led_strip_effect_generator #(
  parameter int LED_COUNT = lseg_pkg::LED_COUNT_DEFAULT
) (
  input  wire logic  clk,
  input  wire logic  rst,
  lseg_cfg_if.sink   cfg,
  lseg_now_if.sink   tick,
  lseg_led_if.source pixel
);
  import lseg_pkg::*;

  mode_t      effect_mode;
  logic [7:0] base_red;
  logic [7:0] base_green;
  logic [7:0] base_blue;
  rgb_t       scaled;

  lseg_job_if job_q ();
  lseg_job_if job_w ();

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      effect_mode <= MODE_OFF;
      base_red    <= 8'd0;
      base_green  <= 8'd0;
      base_blue   <= 8'(BLUE_RESET);
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        CFG_EFFECT_MODE: begin
          effect_mode <= (cfg.data[2:0] > MODE_RAINBOW) ? MODE_RAINBOW
                                                        : mode_t'(cfg.data[2:0]);
        end
        CFG_BASE_RED:   base_red   <= cfg.data;
        CFG_BASE_GREEN: base_green <= cfg.data;
        CFG_BASE_BLUE:  base_blue  <= cfg.data;
        default: ;
      endcase
    end
  end

  // base color scaled to 0..100
  always_ff @(posedge clk) begin
    scaled.red   <= div255(16'(base_red)   * 16'(SCALE_NUM));
    scaled.green <= div255(16'(base_green) * 16'(SCALE_NUM));
    scaled.blue  <= div255(16'(base_blue)  * 16'(SCALE_NUM));
  end

  lseg_front #(.LED_COUNT(LED_COUNT)) u_front (
    .clk     (clk),
    .rst     (rst),
    .mode    (effect_mode),
    .base    (scaled),
    .tick    (tick),
    .job_out (job_q)
  );

  lseg_queue u_queue (
    .clk (clk),
    .rst (rst),
    .wr  (job_q),
    .rd  (job_w)
  );

  lseg_back #(.LED_COUNT(LED_COUNT)) u_back (
    .clk    (clk),
    .rst    (rst),
    .job_in (job_w),
    .pixel  (pixel)
  );

endmodule
`default_nettype wire
